// ===== rtl/lfhs_pkg.sv =====
// Package with constants, types and arithmetic helpers for the fire heat step core.
`default_nettype none

package lfhs_pkg;

  localparam int CFG_W            = 9;
  localparam int MAX_CELLS_DEFAULT = 256;
  localparam int MIN_CELLS        = 3;

  localparam logic [CFG_W-1:0] ACTIVE_CELLS_RESET = 9'd256;

  localparam logic [15:0] PAL_SCALE     = 16'd192;
  localparam logic [7:0]  PAL_RAMP_MASK = 8'h3F;
  localparam logic [7:0]  PAL_BAND_HIGH = 8'h80;
  localparam logic [7:0]  PAL_BAND_MID  = 8'h40;
  localparam logic [7:0]  PAL_FULL      = 8'd255;

  // 683 / 2048 gives exact floor division by three for inputs below 2048.
  localparam logic [20:0] DIV3_RECIP = 21'd683;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] prod;
    prod = 21'(x) * DIV3_RECIP;
    return prod[18:11];
  endfunction

  function automatic rgb_t heat_palette(input logic [7:0] heat);
    logic [15:0] scaled;
    logic [7:0]  t;
    logic [7:0]  ramp;
    rgb_t        c;
    scaled = 16'(heat) * PAL_SCALE;
    t      = scaled[15:8] + 8'(heat != 8'd0);
    ramp   = (t & PAL_RAMP_MASK) << 2;
    if ((t & PAL_BAND_HIGH) != 8'd0) begin
      c = '{red: PAL_FULL, green: PAL_FULL, blue: ramp};
    end else if ((t & PAL_BAND_MID) != 8'd0) begin
      c = '{red: PAL_FULL, green: ramp, blue: 8'd0};
    end else begin
      c = '{red: ramp, green: 8'd0, blue: 8'd0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/led_fire_heat_step_core.sv =====
// An accepted input beat is registered into the second stage, then into the output register.
// Throughput: one cell per cycle while not stalled; heat memory: one read and one write port.
// Reset: synchronous and active low; control state and the frame length register reset.
// After reset a clearing pass writes zero to every heat entry, during which
// in_stall stays high; configuration writes are still taken.
`default_nettype none

module led_fire_heat_step_core #(
  parameter int MAX_CELLS = lfhs_pkg::MAX_CELLS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [lfhs_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_cool_amount,
  input  wire logic [7:0]                 in_spark_amount,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      out_cell_index,
  output logic [7:0]                      out_heat_value,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic                            out_frame_last
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int NW = $clog2(MAX_CELLS + 1);
  localparam int CW = (NW > lfhs_pkg::CFG_W) ? NW : lfhs_pkg::CFG_W;

  logic [7:0] heat_mem [MAX_CELLS];

  logic [lfhs_pkg::CFG_W-1:0] active_cells_r;
  logic                       clr_r, clr_nxt;
  logic [AW-1:0]              clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic                       s1_valid_r, s1_valid_nxt;
  logic [AW-1:0]              s1_pos_r;
  logic [7:0]                 s1_cool_r;
  logic [7:0]                 s1_spark_r;
  logic                       s1_last_r;
  logic [7:0]                 rd_data_r;
  logic [7:0]                 cooled_prev1_r, cooled_prev2_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_cell_index_r, out_heat_value_r;
  logic                       out_frame_last_r;
  lfhs_pkg::rgb_t             out_rgb_r;

  logic [CW-1:0] cfg_ext, frame_len, pos_ext, pos_cur, pos_inc;
  logic          in_accept, s1_adv, cell_last;
  logic [7:0]    cooled, diffused, heat;
  logic [8:0]    heat_sum;
  logic [9:0]    diff_sum;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  lfhs_pkg::rgb_t heat_rgb;

  // Frame length clamp and position of the incoming cell.
  always_comb begin
    cfg_ext = CW'(active_cells_r);
    if (cfg_ext < CW'(lfhs_pkg::MIN_CELLS)) begin
      frame_len = CW'(lfhs_pkg::MIN_CELLS);
    end else if (cfg_ext > CW'(MAX_CELLS)) begin
      frame_len = CW'(MAX_CELLS);
    end else begin
      frame_len = cfg_ext;
    end
    pos_ext   = CW'(pos_r);
    pos_cur   = (pos_ext >= frame_len) ? '0 : pos_ext;
    pos_inc   = pos_cur + CW'(1);
    cell_last = (pos_inc == frame_len);
  end

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = clr_r || (s1_valid_r && !s1_adv);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    pos_nxt       = in_accept ? (cell_last ? '0 : AW'(pos_inc)) : pos_r;
    s1_valid_nxt  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    clr_nxt       = clr_r && (clr_addr_r != AW'(MAX_CELLS - 1));
    clr_addr_nxt  = clr_r ? clr_addr_r + AW'(1) : clr_addr_r;
  end

  // Cooling, upward drift and spark for the cell in the second stage.
  always_comb begin
    cooled   = (rd_data_r > s1_cool_r) ? rd_data_r - s1_cool_r : 8'd0;
    diff_sum = {2'b00, cooled_prev1_r} + {1'b0, cooled_prev2_r, 1'b0};
    diffused = (s1_pos_r < AW'(2)) ? cooled : lfhs_pkg::div3(diff_sum);
    heat_sum = {1'b0, diffused} + {1'b0, s1_spark_r};
    heat     = heat_sum[8] ? lfhs_pkg::PAL_FULL : heat_sum[7:0];
    heat_rgb = lfhs_pkg::heat_palette(heat);
  end

  always_comb begin
    if (clr_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = 8'd0;
    end else begin
      mem_we    = s1_adv;
      mem_waddr = s1_pos_r;
      mem_wdata = heat;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heat_mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_data_r <= heat_mem[AW'(pos_cur)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_cells_r <= lfhs_pkg::ACTIVE_CELLS_RESET;
      clr_r          <= 1'b1;
      clr_addr_r     <= '0;
      pos_r          <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      cooled_prev1_r <= 8'd0;
      cooled_prev2_r <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        active_cells_r <= cfg_wr_data;
      end
      clr_r       <= clr_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pos_r       <= pos_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        cooled_prev2_r <= cooled_prev1_r;
        cooled_prev1_r <= cooled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pos_r   <= AW'(pos_cur);
      s1_cool_r  <= in_cool_amount;
      s1_spark_r <= in_spark_amount;
      s1_last_r  <= cell_last;
    end
    if (s1_adv) begin
      out_cell_index_r <= 8'(CW'(s1_pos_r));
      out_heat_value_r <= heat;
      out_rgb_r        <= heat_rgb;
      out_frame_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_index = out_cell_index_r;
  assign out_heat_value = out_heat_value_r;
  assign out_red        = out_rgb_r.red;
  assign out_green      = out_rgb_r.green;
  assign out_blue       = out_rgb_r.blue;
  assign out_frame_last = out_frame_last_r;

`ifndef ASSERT_OFF
  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (in_stall && !s1_valid_r))
    else $error("input beat possible during heat clearing pass");

  a_stage_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
    else $error("second stage lost a held cell");

  a_clear_ends_at_last_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_r) |-> ($past(clr_addr_r) == AW'(MAX_CELLS - 1)))
    else $error("clearing pass ended early");

  a_palette_bands: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_rgb_r.green != 8'd0)) |-> (out_rgb_r.red == lfhs_pkg::PAL_FULL))
    else $error("palette green band without full red");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/fire_heat_monitor.sv =====
`timescale 1ns / 100ps
// Monitor for the fire heat step core: tracks heat per cell, predicts each result beat and compares.
module fire_heat_monitor (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [lfhs_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic [7:0]                 in_cool_amount,
  input  wire logic [7:0]                 in_spark_amount,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [7:0]                 out_cell_index,
  input  wire logic [7:0]                 out_heat_value,
  input  wire logic [7:0]                 out_red,
  input  wire logic [7:0]                 out_green,
  input  wire logic [7:0]                 out_blue,
  input  wire logic                       out_frame_last,
  output int                              pending,
  output int                              mismatches,
  output int                              cells_checked
);

  localparam int STRIP_CELLS = lfhs_pkg::MAX_CELLS_DEFAULT;

  typedef struct packed {
    logic [7:0]     cell_idx;
    logic [7:0]     heat;
    lfhs_pkg::rgb_t colour;
    logic           frame_end;
  } cell_result_t;

  logic [7:0]                 heat_mem [STRIP_CELLS];
  logic [7:0]                 cooled_last;
  logic [7:0]                 cooled_before;
  int unsigned                position;
  logic [lfhs_pkg::CFG_W-1:0] frame_cfg;
  cell_result_t               expected_cells [$];
  cell_result_t               want;

  function automatic lfhs_pkg::rgb_t heat_colour(input logic [7:0] heat);
    int unsigned    scaled;
    logic [7:0]     band;
    logic [7:0]     ramp;
    lfhs_pkg::rgb_t c;
    scaled = ((heat * lfhs_pkg::PAL_SCALE) >> 8) + ((heat != 8'd0) ? 1 : 0);
    band   = scaled[7:0];
    ramp   = {band[5:0], 2'b00};
    if (band[7]) begin
      c = '{red: lfhs_pkg::PAL_FULL, green: lfhs_pkg::PAL_FULL, blue: ramp};
    end else if (band[6]) begin
      c = '{red: lfhs_pkg::PAL_FULL, green: ramp, blue: 8'd0};
    end else begin
      c = '{red: ramp, green: 8'd0, blue: 8'd0};
    end
    return c;
  endfunction

  function automatic cell_result_t predict_cell(input logic [7:0] cool, input logic [7:0] spark);
    int unsigned  span;
    int unsigned  cooled;
    int unsigned  drift;
    int unsigned  total;
    cell_result_t r;
    span = frame_cfg;
    if (span < lfhs_pkg::MIN_CELLS) span = lfhs_pkg::MIN_CELLS;
    if (span > STRIP_CELLS) span = STRIP_CELLS;
    if (position >= span) position = 0;
    cooled = (heat_mem[position] > cool) ? heat_mem[position] - cool : 0;
    drift = (position < 2) ? cooled : (cooled_last + 2 * cooled_before) / 3;
    cooled_before = cooled_last;
    cooled_last = cooled[7:0];
    total = drift + spark;
    if (total > 255) total = 255;
    heat_mem[position] = total[7:0];
    r.cell_idx  = position[7:0];
    r.heat      = total[7:0];
    r.colour    = heat_colour(total[7:0]);
    r.frame_end = (position + 1 == span);
    position = (position + 1 >= span) ? 0 : position + 1;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0d ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string field, input int got, input int wanted);
    if (got != wanted) begin
      report_mismatch($sformatf("cell %0d %s: got %0d, expected %0d",
                                want.cell_idx, field, got, wanted));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STRIP_CELLS; i++) heat_mem[i] = 8'd0;
      cooled_last = 8'd0;
      cooled_before = 8'd0;
      position = 0;
      frame_cfg = lfhs_pkg::ACTIVE_CELLS_RESET;
      expected_cells.delete();
    end else begin
      if (cfg_wr_en) frame_cfg = cfg_wr_data;
      if (in_valid && !in_stall) begin
        expected_cells.push_back(predict_cell(in_cool_amount, in_spark_amount));
      end
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("result beat for cell %0d with no cell outstanding",
                                    out_cell_index));
        end else begin
          want = expected_cells.pop_front();
          compare_field("cell_index", out_cell_index, want.cell_idx);
          compare_field("heat_value", out_heat_value, want.heat);
          compare_field("red", out_red, want.colour.red);
          compare_field("green", out_green, want.colour.green);
          compare_field("blue", out_blue, want.colour.blue);
          compare_field("frame_last", out_frame_last, want.frame_end);
          cells_checked++;
        end
      end
    end
    pending = expected_cells.size();
  end

endmodule

// ===== tb/sv/led_fire_heat_step_core_test.sv =====
`timescale 1ns / 100ps
// Top-level testbench for the fire heat step core: clock, reset, stimulus, flow control and verdict.
module led_fire_heat_step_core_test;

  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int SEGMENTS     = 8;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [lfhs_pkg::CFG_W-1:0] cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [7:0]                 in_cool_amount;
  logic [7:0]                 in_spark_amount;
  logic                       out_valid;
  logic                       out_stall;
  logic [7:0]                 out_cell_index;
  logic [7:0]                 out_heat_value;
  logic [7:0]                 out_red;
  logic [7:0]                 out_green;
  logic [7:0]                 out_blue;
  logic                       out_frame_last;

  int sender_idle_pct;
  int stall_pct;
  bit hold_request;
  int pending;
  int mismatches;
  int cells_checked;
  int cells_sent;
  int settings_used;

  led_fire_heat_step_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cool_amount (in_cool_amount),
    .in_spark_amount(in_spark_amount),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_index (out_cell_index),
    .out_heat_value (out_heat_value),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_frame_last (out_frame_last)
  );

  fire_heat_monitor heat_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cool_amount (in_cool_amount),
    .in_spark_amount(in_spark_amount),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_index (out_cell_index),
    .out_heat_value (out_heat_value),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_frame_last (out_frame_last),
    .pending        (pending),
    .mismatches     (mismatches),
    .cells_checked  (cells_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 200000);
    $display("Run timed out with %0d results still outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver either stalls at random or, on request, holds off for a long stretch.
  initial begin
    int held;
    bit hold_taken;
    hold_taken = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        held = 0;
        while (held < HOLD_CYCLES) begin
          out_stall <= 1'b1;
          held++;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_cell(input logic [7:0] cool, input logic [7:0] spark);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cool_amount  <= cool;
    in_spark_amount <= spark;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    cells_sent++;
  endtask

  task automatic send_random_cell();
    int         pick;
    logic [7:0] cool;
    logic [7:0] spark;
    pick = $urandom_range(99);
    if (pick < 50) cool = 8'($urandom_range(15));
    else if (pick < 90) cool = 8'($urandom_range(255));
    else cool = $urandom_range(1) ? 8'd255 : 8'd0;
    pick = $urandom_range(99);
    if (pick < 60) spark = 8'd0;
    else if (pick < 85) spark = 8'($urandom_range(255, 160));
    else spark = 8'($urandom_range(255));
    send_cell(cool, spark);
  endtask

  task automatic set_frame_length(input logic [lfhs_pkg::CFG_W-1:0] cells);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cells;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic set_idling(input int mode);
    sender_idle_pct = (mode == 1) ? 72 : (mode == 3) ? 27 : 0;
    stall_pct       = (mode == 2) ? 72 : (mode == 3) ? 27 : 0;
  endtask

  initial begin
    logic [lfhs_pkg::CFG_W-1:0] seg_len [SEGMENTS];
    int                         seg_cells [SEGMENTS];
    int                         drain;
    seg_len   = '{9'd3, 9'd256, 9'd0, 9'd511, 9'd17, 9'd2, 9'd257, 9'd3};
    seg_cells = '{100, 300, 80, 280, 150, 80, 260, 200};
    seg_len[SEGMENTS-1] = 9'($urandom_range(256, 3));
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_cool_amount  = 8'd0;
    in_spark_amount = 8'd0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_request    = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Full sparks, then the heat drifting up a five-cell strip and cooling away.
    set_frame_length(9'd5);
    repeat (3) send_cell(8'd0, 8'd255);
    send_cell(8'd255, 8'd0);
    send_cell(8'd0, 8'd0);
    repeat (3) send_cell(8'd0, 8'd0);
    send_cell(8'd255, 8'd255);
    send_cell(8'd128, 8'd1);
    send_cell(8'd1, 8'd128);
    send_cell(8'd254, 8'd127);
    send_cell(8'd0, 8'd200);
    // Frame lengths below the minimum act as three cells.
    set_frame_length(9'd0);
    repeat (4) send_cell(8'd0, 8'd170);
    set_frame_length(9'd1);
    send_cell(8'd85, 8'd85);
    set_frame_length(9'd2);
    send_cell(8'd0, 8'd0);
    // Lengths beyond the strip act as the full strip; shrinking mid-frame restarts the frame.
    set_frame_length(9'd511);
    repeat (3) send_cell(8'd3, 8'd90);
    set_frame_length(9'd257);
    repeat (3) send_cell(8'd2, 8'd1);
    set_frame_length(9'd3);
    repeat (2) send_cell(8'd0, 8'd64);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_idling(seg % 4);
      set_frame_length(seg_len[seg]);
      if (seg == 4) hold_request = 1'b1;
      repeat (seg_cells[seg]) send_random_cell();
    end

    in_valid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (8) @(negedge clk);
    if (pending != 0) $display("%0d expected result beats never arrived.", pending);
    $display("Sent %0d cells under %0d frame-length writes, out-of-range lengths included.",
             cells_sent, settings_used);
    $display("Checked %0d result beats, with a %0d-cycle receiver hold-off along the way.",
             cells_checked, HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lfhs_pkg.sv
rtl/led_fire_heat_step_core.sv
tb/sv/fire_heat_monitor.sv
tb/sv/led_fire_heat_step_core_test.sv
